// ===== rtl/core/clipped_line_rasterizer_assert.svh =====
// Assertion macros used by the line rasteriser RTL.
`ifndef CLIPPED_LINE_RASTERIZER_ASSERT_SVH
`define CLIPPED_LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CRL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CRL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/crl_pkg.sv =====
// Shared constants, types and helpers for the clipped line rasteriser.
package crl_pkg;

  localparam int COORD_BITS  = 16;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS   = 2 * DIFF_BITS;
  localparam int CNT_BITS    = $clog2(PROD_BITS + 1);
  localparam int DIM_BITS    = 11;
  localparam int PIX_BITS    = 10;
  localparam int OFS_BITS    = 20;
  localparam int COLOUR_BITS = 8;
  localparam int ERR_BITS    = 13;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [DIM_BITS-1:0] MAX_DIM      = 11'd1024;
  localparam logic [DIM_BITS-1:0] RESET_WIDTH  = 11'd320;
  localparam logic [DIM_BITS-1:0] RESET_HEIGHT = 11'd200;

  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;

  localparam logic OP_LINE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [3:0] OC_LEFT   = 4'd1;
  localparam logic [3:0] OC_RIGHT  = 4'd2;
  localparam logic [3:0] OC_BOTTOM = 4'd4;
  localparam logic [3:0] OC_TOP    = 4'd8;

  localparam logic [2:0] MAX_CLIP = 3'd4;

  typedef struct packed {
    logic sel;     // latch edge operands
    logic mul;     // register product and divisor
    logic div_go;  // start divider
    logic upd;     // write clipped endpoint
    logic load;    // load stepping state
  } crl_cmd_t;

  typedef struct packed {
    logic zero_dim;
    logic on_screen;
    logic reject;
    logic den_zero;
    logic div_busy;
    logic active;
  } crl_stat_t;

  function automatic logic [3:0] outcode(input logic signed [COORD_BITS-1:0] x,
                                         input logic signed [COORD_BITS-1:0] y,
                                         input logic [DIM_BITS-1:0] w,
                                         input logic [DIM_BITS-1:0] h);
    logic signed [DIFF_BITS-1:0] xs, ys, ws, hs;
    logic [3:0] c;
    xs = DIFF_BITS'(x);
    ys = DIFF_BITS'(y);
    ws = $signed({{(DIFF_BITS-DIM_BITS){1'b0}}, w});
    hs = $signed({{(DIFF_BITS-DIM_BITS){1'b0}}, h});
    c = '0;
    if (xs < 0)   c = c | OC_LEFT;
    if (xs >= ws) c = c | OC_RIGHT;
    if (ys < 0)   c = c | OC_TOP;
    if (ys >= hs) c = c | OC_BOTTOM;
    return c;
  endfunction

  function automatic logic [DIM_BITS-1:0] sat_dim(input logic [DIM_BITS-1:0] r);
    return (r > MAX_DIM) ? MAX_DIM : r;
  endfunction

endpackage

// ===== rtl/core/clipped_line_rasterizer.sv =====
// Clipped line rasteriser: Cohen-Sutherland clip, then Bresenham pixel stepping.
//
// Input channel (in_*): op selects a line command or a tick. A command carries
// two signed endpoints and a colour; it gives no result and replaces any line
// in progress. A tick emits the next pixel of the active line on out_*, with
// out_last high on the final pixel; a tick with no active line gives nothing.
// Config channel (cfg_*): index 0 is screen width, index 1 screen height;
// always ready; it is to be written only while the block is idle, which the
// block itself does not enforce. Ticks: one per cycle while in_ready is high,
// result registered in the cycle after the transfer. Commands: an on-screen
// line loads the stepping state with no clip step; each clip step runs operand
// select, multiply, divider start, a wait on the 34-step one-bit-per-cycle
// divider and update, at most four steps. in_ready is low while a command runs.
// A finished pixel waits in the output register; the next input is taken in
// the cycle the receiver takes it, so a stalled receiver stalls the input.
// Reset (rst_n low, synchronous) drops any line, clears the output and sets
// the screen to 320 by 200.
module clipped_line_rasterizer import crl_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic [COLOUR_BITS-1:0]       in_colour_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [PIX_BITS-1:0]          out_pixel_x,
  output logic [PIX_BITS-1:0]          out_pixel_y,
  output logic [OFS_BITS-1:0]          out_pixel_offset,
  output logic [COLOUR_BITS-1:0]       out_colour_out,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [DIM_BITS-1:0]          cfg_data
);

  `include "clipped_line_rasterizer_assert.svh"

  logic [DIM_BITS-1:0] width_r, height_r;
  crl_cmd_t  cmd;
  crl_stat_t stat;
  logic      idle, in_xfer, line_accept, tick_accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH)  width_r  <= cfg_data;
      if (cfg_index == REG_HEIGHT) height_r <= cfg_data;
    end
  end

  assign in_ready    = idle && (!out_valid || out_ready);
  assign in_xfer     = in_valid && in_ready;
  assign line_accept = in_xfer && (in_op == OP_LINE);
  assign tick_accept = in_xfer && (in_op == OP_TICK);

  crl_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .line_accept (line_accept),
    .stat        (stat),
    .cmd         (cmd),
    .idle        (idle)
  );

  crl_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .view_width    (width_r),
    .view_height   (height_r),
    .line_accept   (line_accept),
    .tick_accept   (tick_accept),
    .start_x       (in_start_x),
    .start_y       (in_start_y),
    .end_x         (in_end_x),
    .end_y         (in_end_y),
    .colour_in     (in_colour_in),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .pixel_x       (out_pixel_x),
    .pixel_y       (out_pixel_y),
    .pixel_offset  (out_pixel_offset),
    .colour_out    (out_colour_out),
    .last          (out_last)
  );

  // a command always enters the clip sequencer, so in_ready is low in the cycle after it is taken
  `CRL_ASSERT_NXT(a_line_blocks, line_accept, !in_ready)
  // a result appears only after a tick transfer
  `CRL_ASSERT_NXT(a_no_spurious_out, (!out_valid || out_ready) && !tick_accept, !out_valid)
  // a command drops the line in progress
  `CRL_ASSERT_NXT(a_line_clears, line_accept, !stat.active)
  // the stepping state is loaded only with both endpoints on screen
  `CRL_ASSERT_IMP(a_load_on_screen, cmd.load, stat.on_screen && !stat.zero_dim)

endmodule

// ===== rtl/core/crl_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
module crl_div import crl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [PROD_BITS-1:0] dividend,
  input  logic [DIFF_BITS-1:0] divisor,
  output logic                 busy,
  output logic [PROD_BITS-1:0] quotient
);

  logic [DIFF_BITS-1:0] rem_r, rem_nxt;
  logic [PROD_BITS-1:0] dvd_r, dvd_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [DIFF_BITS:0]   trial;
  logic                 qbit;

  always_comb begin
    trial    = {rem_r, dvd_r[PROD_BITS-1]};
    qbit     = (trial >= {1'b0, divisor});
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      cnt_nxt  = CNT_BITS'(PROD_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = qbit ? DIFF_BITS'(trial - {1'b0, divisor}) : trial[DIFF_BITS-1:0];
      dvd_nxt  = {dvd_r[PROD_BITS-2:0], qbit};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign busy     = busy_r;
  assign quotient = dvd_r;

endmodule

// ===== rtl/core/crl_dp.sv =====
// Datapath: clip endpoints and operands, divider, Bresenham state, output register.
module crl_dp import crl_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  crl_cmd_t                      cmd,
  output crl_stat_t                     stat,
  input  logic [DIM_BITS-1:0]           view_width,
  input  logic [DIM_BITS-1:0]           view_height,
  input  logic                          line_accept,
  input  logic                          tick_accept,
  input  logic signed [COORD_BITS-1:0]  start_x,
  input  logic signed [COORD_BITS-1:0]  start_y,
  input  logic signed [COORD_BITS-1:0]  end_x,
  input  logic signed [COORD_BITS-1:0]  end_y,
  input  logic [COLOUR_BITS-1:0]        colour_in,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [PIX_BITS-1:0]           pixel_x,
  output logic [PIX_BITS-1:0]           pixel_y,
  output logic [OFS_BITS-1:0]           pixel_offset,
  output logic [COLOUR_BITS-1:0]        colour_out,
  output logic                          last
);

  logic [DIM_BITS-1:0] w_dim, h_dim;
  assign w_dim = sat_dim(view_width);
  assign h_dim = sat_dim(view_height);

  // clip state
  logic signed [COORD_BITS-1:0] x1_r, y1_r, x2_r, y2_r, base_r, fix_r;
  logic signed [DIFF_BITS-1:0]  num_r, t_r, den_r;
  logic                         horiz_r, first_r, neg_r;
  logic [PROD_BITS-1:0]         prod_r;
  logic [DIFF_BITS-1:0]         dmag_r;
  logic [COLOUR_BITS-1:0]       colour_r;

  logic [3:0] c1, c2, csel;
  logic signed [DIFF_BITS-1:0] dx, dy, x1e, y1e;
  logic signed [DIFF_BITS-1:0] wm1, hm1;

  assign c1   = outcode(x1_r, y1_r, w_dim, h_dim);
  assign c2   = outcode(x2_r, y2_r, w_dim, h_dim);
  assign csel = (c1 != 4'd0) ? c1 : c2;
  assign x1e  = DIFF_BITS'(x1_r);
  assign y1e  = DIFF_BITS'(y1_r);
  assign dx   = DIFF_BITS'(x2_r) - x1e;
  assign dy   = DIFF_BITS'(y2_r) - y1e;
  assign wm1  = $signed({{(DIFF_BITS-DIM_BITS){1'b0}}, w_dim}) - DIFF_BITS'(1);
  assign hm1  = $signed({{(DIFF_BITS-DIM_BITS){1'b0}}, h_dim}) - DIFF_BITS'(1);

  // multiply and divide
  logic [DIFF_BITS-1:0] num_mag, t_mag;
  logic                 div_busy;
  logic [PROD_BITS-1:0] quot;
  assign num_mag = num_r[DIFF_BITS-1] ? DIFF_BITS'(-num_r) : DIFF_BITS'(num_r);
  assign t_mag   = t_r[DIFF_BITS-1]   ? DIFF_BITS'(-t_r)   : DIFF_BITS'(t_r);

  crl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (prod_r),
    .divisor  (dmag_r),
    .busy     (div_busy),
    .quotient (quot)
  );

  // new point stays inside the segment's box, so the quotient fits DIFF_BITS
  logic signed [DIFF_BITS:0] qv, res;
  assign qv  = $signed({1'b0, quot[DIFF_BITS-1:0]});
  assign res = neg_r ? ((DIFF_BITS+1)'(base_r) - qv) : ((DIFF_BITS+1)'(base_r) + qv);

  always_ff @(posedge clk) begin
    if (line_accept) begin
      x1_r     <= start_x;
      y1_r     <= start_y;
      x2_r     <= end_x;
      y2_r     <= end_y;
      colour_r <= colour_in;
    end else if (cmd.upd) begin
      if (first_r) begin
        x1_r <= horiz_r ? res[COORD_BITS-1:0] : fix_r;
        y1_r <= horiz_r ? fix_r : res[COORD_BITS-1:0];
      end else begin
        x2_r <= horiz_r ? res[COORD_BITS-1:0] : fix_r;
        y2_r <= horiz_r ? fix_r : res[COORD_BITS-1:0];
      end
    end
    if (cmd.sel) begin
      first_r <= (c1 != 4'd0);
      // edge order: bottom, top, right, left
      if ((csel & OC_BOTTOM) != 4'd0) begin
        horiz_r <= 1'b1; fix_r <= COORD_BITS'(hm1);
        t_r <= hm1 - y1e; num_r <= dx; den_r <= dy; base_r <= x1_r;
      end else if ((csel & OC_TOP) != 4'd0) begin
        horiz_r <= 1'b1; fix_r <= '0;
        t_r <= -y1e; num_r <= dx; den_r <= dy; base_r <= x1_r;
      end else if ((csel & OC_RIGHT) != 4'd0) begin
        horiz_r <= 1'b0; fix_r <= COORD_BITS'(wm1);
        t_r <= wm1 - x1e; num_r <= dy; den_r <= dx; base_r <= y1_r;
      end else begin
        horiz_r <= 1'b0; fix_r <= '0;
        t_r <= -x1e; num_r <= dy; den_r <= dx; base_r <= y1_r;
      end
    end
    if (cmd.mul) begin
      prod_r <= num_mag * t_mag;
      dmag_r <= den_r[DIFF_BITS-1] ? DIFF_BITS'(-den_r) : DIFF_BITS'(den_r);
      neg_r  <= (num_r[DIFF_BITS-1] ^ t_r[DIFF_BITS-1]) ^ den_r[DIFF_BITS-1];
    end
  end

  // Bresenham stepping state
  logic                       active_r, active_nxt;
  logic [DIM_BITS-1:0]        cur_x_r, cur_y_r, stop_x_r, stop_y_r, span_x_r, span_y_r;
  logic                       sxn_r, syn_r;
  logic signed [ERR_BITS-1:0] err_r;
  logic [COLOUR_BITS-1:0]     line_colour_r;

  logic [DIM_BITS-1:0]        lx1, ly1, lx2, ly2;
  logic                       fin, step_x, step_y;
  logic signed [ERR_BITS:0]   e2, sx_e, sy_e;
  logic signed [ERR_BITS-1:0] err_nxt;

  assign lx1 = x1_r[DIM_BITS-1:0];
  assign ly1 = y1_r[DIM_BITS-1:0];
  assign lx2 = x2_r[DIM_BITS-1:0];
  assign ly2 = y2_r[DIM_BITS-1:0];

  assign fin    = (cur_x_r == stop_x_r) && (cur_y_r == stop_y_r);
  assign e2     = {err_r, 1'b0};
  assign sx_e   = $signed({{(ERR_BITS+1-DIM_BITS){1'b0}}, span_x_r});
  assign sy_e   = $signed({{(ERR_BITS+1-DIM_BITS){1'b0}}, span_y_r});
  assign step_x = (e2 > -sy_e);
  assign step_y = (e2 < sx_e);

  always_comb begin
    err_nxt = err_r;
    if (step_x) err_nxt = err_nxt - ERR_BITS'(sy_e);
    if (step_y) err_nxt = err_nxt + ERR_BITS'(sx_e);
  end

  always_comb begin
    active_nxt = active_r;
    if (line_accept) active_nxt = 1'b0;
    else if (cmd.load) active_nxt = 1'b1;
    else if (tick_accept && active_r && fin) active_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
    if (cmd.load) begin
      cur_x_r       <= lx1;
      cur_y_r       <= ly1;
      stop_x_r      <= lx2;
      stop_y_r      <= ly2;
      span_x_r      <= (lx1 < lx2) ? lx2 - lx1 : lx1 - lx2;
      span_y_r      <= (ly1 < ly2) ? ly2 - ly1 : ly1 - ly2;
      sxn_r         <= !(lx1 < lx2);
      syn_r         <= !(ly1 < ly2);
      err_r         <= ERR_BITS'((lx1 < lx2) ? lx2 - lx1 : lx1 - lx2)
                     - ERR_BITS'((ly1 < ly2) ? ly2 - ly1 : ly1 - ly2);
      line_colour_r <= colour_r;
    end else if (tick_accept && active_r && !fin) begin
      err_r <= err_nxt;
      if (step_x) cur_x_r <= sxn_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
      if (step_y) cur_y_r <= syn_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    end
  end

  // output register
  logic                   out_valid_r;
  logic [PIX_BITS-1:0]    px_r, py_r;
  logic [OFS_BITS-1:0]    ofs_r;
  logic [COLOUR_BITS-1:0] col_r;
  logic                   last_r;
  logic [PIX_BITS+DIM_BITS-1:0] ofs_full;

  assign ofs_full = (PIX_BITS+DIM_BITS)'(cur_y_r[PIX_BITS-1:0])
                  * (PIX_BITS+DIM_BITS)'(w_dim)
                  + (PIX_BITS+DIM_BITS)'(cur_x_r[PIX_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick_accept && active_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (tick_accept && active_r) begin
      px_r   <= cur_x_r[PIX_BITS-1:0];
      py_r   <= cur_y_r[PIX_BITS-1:0];
      ofs_r  <= ofs_full[OFS_BITS-1:0];
      col_r  <= line_colour_r;
      last_r <= fin;
    end
  end

  assign out_valid    = out_valid_r;
  assign pixel_x      = px_r;
  assign pixel_y      = py_r;
  assign pixel_offset = ofs_r;
  assign colour_out   = col_r;
  assign last         = last_r;

  assign stat.zero_dim  = (w_dim == '0) || (h_dim == '0);
  assign stat.on_screen = ((c1 | c2) == 4'd0);
  assign stat.reject    = ((c1 & c2) != 4'd0);
  assign stat.den_zero  = (den_r == '0);
  assign stat.div_busy  = div_busy;
  assign stat.active    = active_r;

endmodule

// ===== rtl/core/crl_ctrl.sv =====
// Controller: sequences the clip iterations and the stepping-state load.
module crl_ctrl import crl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      line_accept,
  input  crl_stat_t stat,
  output crl_cmd_t  cmd,
  output logic      idle
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_MUL, ST_DIV_GO, ST_DIV_WAIT, ST_UPDATE
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] iter_r, iter_nxt;

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (line_accept) begin
          state_nxt = ST_CHECK;
          iter_nxt  = '0;
        end
      end
      ST_CHECK: begin
        if (stat.zero_dim) begin
          state_nxt = ST_IDLE;
        end else if (stat.on_screen) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (stat.reject || iter_r == MAX_CLIP) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.sel   = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (stat.den_zero) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!stat.div_busy) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.upd   = 1'b1;
        iter_nxt  = iter_r + 1'b1;
        state_nxt = ST_CHECK;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  assign idle = (state_r == ST_IDLE);

endmodule
